### rtl/xcfr_pkg.sv
// shared types and constants of the xor checked frame receiver
// no dependencies; imported by every module of the block
`default_nettype none

package xcfr_pkg;

	localparam int MAX_PAYLOAD = 60;
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE  = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0] HEAD_BYTE_RST = BYTE_W'(170);
	localparam logic [BYTE_W-1:0] ACK_CODE_RST  = BYTE_W'(1);

	// acknowledge frame beats
	localparam logic [1:0] BEAT_HEAD = 2'd0;
	localparam logic [1:0] BEAT_ACK  = 2'd1;
	localparam logic [1:0] BEAT_ZERO = 2'd2;
	localparam logic [1:0] BEAT_CHK  = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] head_byte;
		logic [BYTE_W-1:0] ack_code;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
	} ack_event_t;

	typedef struct packed {
		logic       push;
		ack_event_t entry;
	} push_t;

	typedef struct packed {
		logic       not_empty;
		ack_event_t entry;
	} head_t;

endpackage

`default_nettype wire

### rtl/xcfr_rx_if.sv
// receive byte channel: valid/ready handshake carrying one received word
// depends on xcfr_pkg
`default_nettype none

interface xcfr_rx_if import xcfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/xcfr_tx_if.sv
// transmit channel: acknowledge words plus command report
// depends on xcfr_pkg
`default_nettype none

interface xcfr_tx_if import xcfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tx_byte;
	logic              tx_last;
	logic              cmd_valid;
	logic [BYTE_W-1:0] cmd_code;
	logic [LEN_W-1:0]  payload_count;

	modport source (output valid, output tx_byte, output tx_last, output cmd_valid,
		output cmd_code, output payload_count, input ready);
	modport sink (input valid, input tx_byte, input tx_last, input cmd_valid,
		input cmd_code, input payload_count, output ready);
endinterface

`default_nettype wire

### rtl/xcfr_cfg_if.sv
// configuration write channel: register index and write data
// depends on xcfr_pkg
`default_nettype none

interface xcfr_cfg_if import xcfr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/xcfr_front.sv
// front end: hunts for the header, tracks the frame and checks the xor
// depends on xcfr_pkg and xcfr_rx_if; pushes good frames to the queue
`default_nettype none

module xcfr_front import xcfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	xcfr_rx_if.sink    rx,
	input  wire logic  q_full,
	input  wire cfg_t  cfg,
	output push_t      push
);

	localparam logic [2:0] ST_HUNT  = 3'd0;
	localparam logic [2:0] ST_CMD   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;

	logic [2:0]        state_q;
	logic [BYTE_W-1:0] chk_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  remain_q;
	logic              take;

	assign rx.ready = !q_full;
	assign take     = rx.valid && rx.ready;

	assign push.push      = take && (state_q == ST_CHECK) && (rx.rx_byte == chk_q);
	assign push.entry.cmd = cmd_q;
	assign push.entry.len = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HUNT;
			chk_q    <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
			remain_q <= '0;
		end else if (take) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx.rx_byte == cfg.head_byte) state_q <= ST_CMD;
				end
				ST_CMD: begin
					cmd_q   <= rx.rx_byte;
					chk_q   <= rx.rx_byte;
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					if (rx.rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
						state_q <= ST_HUNT;
					end else begin
						len_q    <= rx.rx_byte[LEN_W-1:0];
						remain_q <= rx.rx_byte[LEN_W-1:0];
						chk_q    <= chk_q ^ rx.rx_byte;
						state_q  <= (rx.rx_byte == '0) ? ST_CHECK : ST_DATA;
					end
				end
				ST_DATA: begin
					chk_q    <= chk_q ^ rx.rx_byte;
					remain_q <= remain_q - LEN_W'(1);
					if (remain_q == LEN_W'(1)) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_HUNT;
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/xcfr_queue.sv
// short queue of good frame events between front and back ends
// depends on xcfr_pkg
`default_nettype none

module xcfr_queue import xcfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output head_t      head,
	output logic       full
);

	ack_event_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full           = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.not_empty = (count_q != '0);
	assign head.entry     = mem_q[rd_ptr_q];
	assign do_pop         = pop && head.not_empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push.push) mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push.push && !do_pop) count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !push.push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/xcfr_back.sv
// back end: sends the four word acknowledge frame through an output register
// depends on xcfr_pkg and xcfr_tx_if; pops events from the queue
`default_nettype none

module xcfr_back import xcfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire head_t head,
	input  wire cfg_t  cfg,
	output logic       pop,
	xcfr_tx_if.source  tx
);

	logic [1:0]        beat_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              cmd_valid_q;
	logic [BYTE_W-1:0] cmd_code_q;
	logic [LEN_W-1:0]  count_q;
	logic              load;
	logic              emit;

	assign load = !valid_q || tx.ready;
	assign pop  = load && (beat_q == BEAT_HEAD) && head.not_empty;
	assign emit = load && ((beat_q != BEAT_HEAD) || head.not_empty);

	assign tx.valid         = valid_q;
	assign tx.tx_byte       = byte_q;
	assign tx.tx_last       = last_q;
	assign tx.cmd_valid     = cmd_valid_q;
	assign tx.cmd_code      = cmd_code_q;
	assign tx.payload_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_HEAD;
		end else if (load) begin
			valid_q <= emit;
			if (emit) beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_q      <= 1'b0;
			cmd_valid_q <= 1'b0;
			cmd_code_q  <= '0;
			count_q     <= '0;
			unique case (beat_q)
				BEAT_HEAD: begin
					byte_q      <= cfg.head_byte;
					cmd_valid_q <= 1'b1;
					cmd_code_q  <= head.entry.cmd;
					count_q     <= head.entry.len;
				end
				BEAT_ACK: begin
					byte_q <= cfg.ack_code;
				end
				BEAT_ZERO: begin
					byte_q <= '0;
				end
				BEAT_CHK: begin
					byte_q <= cfg.ack_code;
					last_q <= 1'b1;
				end
				default: begin
					byte_q <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/xor_checked_frame_receiver.sv
// xor checked frame receiver: takes received bytes, checks each frame's
// xor and answers every good frame with a four word acknowledge frame
// rx channel: one received byte per word. tx channel: acknowledge words;
// the first carries cmd_valid with the frame's command and payload length,
// the fourth carries tx_last. cfg channel: index 0 header byte (reset 170),
// index 1 ack code (reset 1); writes are taken in any cycle.
// A frame is header, command, length, payload, check byte; the check byte
// must equal the xor of command, length and payload. Bad checks and lengths
// above the maximum payload are dropped without a reply.
// A good frame's event is queued; the first acknowledge word is
// registered when it is popped, the rest one per cycle while tx is ready.
// Throughput: one rx word per cycle. A two entry event queue sits between
// the deframer and the output sequencer; rx.ready falls only while that
// queue is full, which happens when tx stalls across several good frames.
// The sequencer sends four words per good frame, one per cycle if tx is ready.
// Reset clears the deframer to header hunting, empties the queue and the
// output register, and restores both configuration registers.
// depends on xcfr_pkg, the interfaces, xcfr_front, xcfr_queue, xcfr_back
`default_nettype none

module xor_checked_frame_receiver import xcfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	xcfr_rx_if.sink    rx,
	xcfr_tx_if.source  tx,
	xcfr_cfg_if.sink   cfg
);

	cfg_t  cfg_q;
	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte <= HEAD_BYTE_RST;
			cfg_q.ack_code  <= ACK_CODE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HEAD_BYTE: cfg_q.head_byte <= cfg.data;
				REG_ACK_CODE:  cfg_q.ack_code  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	xcfr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.cfg    (cfg_q),
		.push   (push)
	);

	xcfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	xcfr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.cfg    (cfg_q),
		.pop    (pop),
		.tx     (tx)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !q_full)
		else $error("event pushed into a full queue");

	a_pop_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> tx.valid && tx.cmd_valid && !tx.tx_last)
		else $error("popped event did not start an acknowledge frame");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.cmd_valid |-> tx.payload_count <= LEN_W'(MAX_PAYLOAD))
		else $error("reported payload count above maximum");
`endif

endmodule

`default_nettype wire
